### design/stepper_valve_homing_stepper_macros.svh
// Assertion macros shared by the valve stepper RTL.
// Included by files that carry concurrent checks; relies on ports clock and reset.
`ifndef STEPPER_VALVE_HOMING_STEPPER_MACROS_SVH
`define STEPPER_VALVE_HOMING_STEPPER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, gated off during reset
`define SVH_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("valve stepper check failed");
// Next-cycle implication, gated off during reset
`define SVH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("valve stepper check failed");
`else
`define SVH_ASSERT_IMPLY(lbl, ante, cons)
`define SVH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/svh_pkg.sv
// Shared types, constants and helper functions for the valve stepper drive.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package svh_pkg;

   // Field widths
   localparam int NUM_MOTORS_DEF = 8;
   localparam int MOTOR_W        = 4;
   localparam int COUNT_W        = 16;
   localparam int OFFSET_W       = 8;
   localparam int SENSOR_W       = 8;
   localparam int PATTERN_W      = 4;
   localparam int VALVE_W        = 4;
   localparam int PERIOD_W       = 6;
   localparam int ERRORS_W       = 8;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 8;

   // Gear scaling: count * 1757 / 1024
   localparam int                   GEAR_MUL_W = 11;
   localparam logic [GEAR_MUL_W-1:0] GEAR_MUL  = 11'd1757;
   localparam int                   GEAR_SHIFT = 10;
   localparam int                   PROD_W     = COUNT_W + GEAR_MUL_W;

   // Origin search and offset trimming
   localparam logic [OFFSET_W-1:0] ORIGIN_LIMIT = 8'd150;
   localparam logic [OFFSET_W-1:0] TRIM_HI_LIM  = 8'd64;
   localparam logic [OFFSET_W-1:0] TRIM_MID_LIM = 8'd32;
   localparam logic [OFFSET_W-1:0] TRIM_LO_LIM  = 8'd16;
   localparam logic [OFFSET_W-1:0] TRIM_HI      = 8'd48;
   localparam logic [OFFSET_W-1:0] TRIM_MID     = 8'd24;
   localparam logic [OFFSET_W-1:0] TRIM_LO      = 8'd12;

   // Tick periods by gear
   localparam logic [PERIOD_W-1:0] PERIOD_60  = 6'd30;
   localparam logic [PERIOD_W-1:0] PERIOD_103 = 6'd45;

   // Motors above this number sit on the second coil side
   localparam logic [MOTOR_W-1:0] SIDE_SPLIT = 4'd4;

   // Request kinds
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GEAR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERRUN_EN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERRUN_STP = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_CHK   = 2'd3;

   typedef struct packed {
      logic                  gear_ratio_mode;
      logic                  overrun_enable;
      logic [OFFSET_W-1:0]   overrun_steps;
      logic                  close_check_enable;
   } svh_cfg_type;

   typedef struct packed {
      logic                  req_type;
      logic [MOTOR_W-1:0]    motor_id;
      logic                  direction;
      logic [COUNT_W-1:0]    step_count;
      logic                  homing_mode;
      logic                  arm_close_check;
      logic [SENSOR_W-1:0]   origin_sensors;
   } svh_req_type;

   typedef struct packed {
      logic [1:0]            phase_index;
      logic                  active_side;
      logic [MOTOR_W-1:0]    active_motor;
      logic                  run_direction;
      logic                  run_active;
      logic [COUNT_W-1:0]    steps_left;
      logic [OFFSET_W-1:0]   origin_count;
      logic                  run_homing;
      logic                  close_armed;
      logic                  reversal_done;
   } svh_state_type;

   typedef struct packed {
      logic [PATTERN_W-1:0]  coil_pattern;
      logic                  coil_side;
      logic [VALVE_W-1:0]    valve_enable;
      logic                  running;
      logic [PERIOD_W-1:0]   tick_period;
      logic [ERRORS_W-1:0]   close_errors;
      logic [OFFSET_W-1:0]   stored_offset;
   } svh_rsp_type;

   // Full-step coil pattern for each phase
   function automatic logic [PATTERN_W-1:0] coil_of(input logic [1:0] phase);
      logic [PATTERN_W-1:0] pat;
      case (phase)
         2'd0:    pat = 4'd6;
         2'd1:    pat = 4'd10;
         2'd2:    pat = 4'd9;
         default: pat = 4'd5;
      endcase
      return pat;
   endfunction

   // One-hot valve line; the second side counts down from the top bit
   function automatic logic [VALVE_W-1:0] valve_of(input logic [MOTOR_W-1:0] motor);
      logic [VALVE_W-1:0] v;
      case (motor)
         4'd1, 4'd8: v = 4'b0001;
         4'd2, 4'd7: v = 4'b0010;
         4'd3, 4'd6: v = 4'b0100;
         4'd4, 4'd5: v = 4'b1000;
         default:    v = '0;
      endcase
      return v;
   endfunction

   // Trim a found origin count by size band
   function automatic logic [OFFSET_W-1:0] trim_offset(input logic [OFFSET_W-1:0] c);
      logic [OFFSET_W-1:0] t;
      if (c > TRIM_HI_LIM) begin
         t = c - TRIM_HI;
      end else if (c > TRIM_MID_LIM) begin
         t = c - TRIM_MID;
      end else if (c > TRIM_LO_LIM) begin
         t = c - TRIM_LO;
      end else begin
         t = c;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

### design/svh_step.sv
// Single-pass next-state and result logic for one command or tick word.
// Depends on svh_pkg for types, constants and the coil/valve/trim helpers.
`timescale 1ns / 1ps
`default_nettype none

module svh_step #(
   parameter int NUM_MOTORS = svh_pkg::NUM_MOTORS_DEF
) (
   input  svh_pkg::svh_req_type                          req,
   input  svh_pkg::svh_cfg_type                          cfg,
   input  svh_pkg::svh_state_type                        cur_state,
   input  logic [NUM_MOTORS-1:0][svh_pkg::OFFSET_W-1:0]  cur_offsets,
   input  logic [NUM_MOTORS-1:0]                         cur_flags,
   output svh_pkg::svh_state_type                        nxt_state,
   output logic [NUM_MOTORS-1:0][svh_pkg::OFFSET_W-1:0]  nxt_offsets,
   output logic [NUM_MOTORS-1:0]                         nxt_flags,
   output svh_pkg::svh_rsp_type                          rsp
);

   localparam int IDX_W = $clog2(NUM_MOTORS);

   svh_pkg::svh_state_type            st_a;
   logic                              req_motor_ok;
   logic                              cur_motor_ok;
   logic                              sel_motor_ok;
   logic                              cmd_ok;
   logic [svh_pkg::MOTOR_W-1:0]       sel_motor;
   logic [IDX_W-1:0]                  idx;
   logic [NUM_MOTORS-1:0]             sensors_sub;
   logic                              sensor;
   logic                              logical_dir;
   logic [svh_pkg::OFFSET_W-1:0]      rd_off;
   logic [svh_pkg::OFFSET_W-1:0]      oc_inc;
   logic [svh_pkg::COUNT_W-1:0]       steps_dec;
   logic [svh_pkg::PATTERN_W-1:0]     pattern;
   logic                              halt;
   logic                              start;
   logic                              start_dir;
   logic [svh_pkg::COUNT_W-1:0]       start_count;
   logic                              wr_off;
   logic [svh_pkg::OFFSET_W-1:0]      wr_data;
   logic                              set_flag;
   logic [svh_pkg::PROD_W-1:0]        prod;
   logic [svh_pkg::COUNT_W:0]         scaled_raw;
   logic [svh_pkg::COUNT_W-1:0]       scaled;

   // Motor range checks and the one offset read
   assign req_motor_ok = (req.motor_id != '0)
                      && (req.motor_id <= svh_pkg::MOTOR_W'(NUM_MOTORS));
   assign cur_motor_ok = (cur_state.active_motor != '0)
                      && (cur_state.active_motor <= svh_pkg::MOTOR_W'(NUM_MOTORS));
   assign cmd_ok       = (req.step_count != '0) && req_motor_ok;
   assign sel_motor    = (req.req_type == svh_pkg::REQ_START && cmd_ok)
                       ? req.motor_id : cur_state.active_motor;
   assign sel_motor_ok = (sel_motor != '0)
                      && (sel_motor <= svh_pkg::MOTOR_W'(NUM_MOTORS));
   assign idx          = IDX_W'(sel_motor - svh_pkg::MOTOR_W'(1));
   assign rd_off       = sel_motor_ok ? cur_offsets[idx] : '0;

   assign sensors_sub  = req.origin_sensors[NUM_MOTORS-1:0];
   assign sensor       = sensors_sub[idx];
   assign logical_dir  = cur_state.run_direction ^ cfg.gear_ratio_mode;
   assign oc_inc       = cur_state.origin_count + svh_pkg::OFFSET_W'(1);
   assign steps_dec    = cur_state.steps_left - svh_pkg::COUNT_W'(1);

   // Decide the command or tick outcome
   always_comb begin
      st_a        = cur_state;
      pattern     = '0;
      halt        = 1'b0;
      start       = 1'b0;
      start_dir   = ~cur_state.run_direction;
      start_count = svh_pkg::COUNT_W'(cfg.overrun_steps) + svh_pkg::COUNT_W'(1);
      wr_off      = 1'b0;
      wr_data     = svh_pkg::ORIGIN_LIMIT;
      set_flag    = 1'b0;
      if (req.req_type == svh_pkg::REQ_START) begin
         st_a.run_active = 1'b0;
         if (cmd_ok) begin
            start              = 1'b1;
            start_dir          = req.direction;
            start_count        = req.step_count;
            st_a.run_homing    = req.homing_mode;
            st_a.close_armed   = req.arm_close_check;
            st_a.reversal_done = 1'b0;
         end
      end else if (cur_state.run_active) begin
         if (!cur_motor_ok) begin
            st_a.run_active = 1'b0;
         end else begin
            // Drive this phase, advance the pattern
            pattern          = svh_pkg::coil_of(cur_state.phase_index);
            st_a.phase_index = cur_state.run_direction ? cur_state.phase_index - 2'd1
                                                       : cur_state.phase_index + 2'd1;
            if (!cur_state.run_homing) begin
               // Count closing steps off the origin, stop at the stored offset
               if (!sensor && !logical_dir) begin
                  st_a.origin_count = oc_inc;
                  if (oc_inc == rd_off) begin
                     st_a.close_armed = 1'b0;
                     st_a.run_active  = 1'b0;
                     pattern          = '0;
                     halt             = 1'b1;
                  end
               end else begin
                  st_a.origin_count = '0;
               end
            end else begin
               // Origin search: store the trimmed count, or the limit on timeout
               if (sensor) begin
                  st_a.run_active = 1'b0;
                  pattern         = '0;
                  wr_off          = 1'b1;
                  wr_data         = svh_pkg::trim_offset(cur_state.origin_count);
                  halt            = 1'b1;
               end else begin
                  st_a.origin_count = oc_inc;
                  if (oc_inc >= svh_pkg::ORIGIN_LIMIT) begin
                     st_a.run_active = 1'b0;
                     pattern         = '0;
                     wr_off          = 1'b1;
                     wr_data         = svh_pkg::ORIGIN_LIMIT;
                     halt            = 1'b1;
                  end
               end
            end
            // Step count, end-of-run checks and the single reversal
            if (!halt) begin
               st_a.steps_left = steps_dec;
               if (steps_dec == '0) begin
                  set_flag = cfg.close_check_enable & cur_state.close_armed;
                  pattern  = '0;
                  if (cfg.overrun_enable && !cur_state.reversal_done) begin
                     st_a.reversal_done = 1'b1;
                     st_a.phase_index   = st_a.phase_index ^ 2'd2;
                     start              = 1'b1;
                  end else begin
                     st_a.run_active = 1'b0;
                  end
               end
            end
         end
      end
   end

   // Gear scaling with saturation
   assign prod       = svh_pkg::PROD_W'(start_count) * svh_pkg::PROD_W'(svh_pkg::GEAR_MUL);
   assign scaled_raw = prod[svh_pkg::PROD_W-1:svh_pkg::GEAR_SHIFT];
   assign scaled     = scaled_raw[svh_pkg::COUNT_W] ? '1 : scaled_raw[svh_pkg::COUNT_W-1:0];

   // Apply a run start
   always_comb begin
      nxt_state = st_a;
      if (start) begin
         nxt_state.active_side   = (sel_motor > svh_pkg::SIDE_SPLIT);
         nxt_state.active_motor  = sel_motor;
         nxt_state.run_direction = start_dir ^ cfg.gear_ratio_mode;
         nxt_state.origin_count  = '0;
         nxt_state.steps_left    = cfg.gear_ratio_mode ? scaled : start_count;
         nxt_state.run_active    = 1'b1;
      end
   end

   // Offset and error flag updates
   always_comb begin
      nxt_offsets = cur_offsets;
      nxt_flags   = cur_flags;
      if (wr_off) begin
         nxt_offsets[idx] = wr_data;
      end
      if (set_flag) begin
         nxt_flags[idx] = 1'b1;
      end
   end

   // Result word, taken from the updated state
   always_comb begin
      rsp.coil_pattern  = nxt_state.run_active ? pattern : '0;
      rsp.coil_side     = nxt_state.active_side;
      rsp.valve_enable  = nxt_state.run_active ? svh_pkg::valve_of(nxt_state.active_motor)
                                               : '0;
      rsp.running       = nxt_state.run_active;
      rsp.tick_period   = cfg.gear_ratio_mode ? svh_pkg::PERIOD_103 : svh_pkg::PERIOD_60;
      rsp.close_errors  = svh_pkg::ERRORS_W'(nxt_flags);
      rsp.stored_offset = wr_off ? wr_data : rd_off;
   end

endmodule

`default_nettype wire

### design/svh_rsp_reg.sv
// Result register with valid/ready: holds one result word until it is taken.
// Depends on svh_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module svh_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  svh_pkg::svh_rsp_type load_data,
   output logic                 load_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output svh_pkg::svh_rsp_type out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   svh_pkg::svh_rsp_type data_ff;

   // Refill in the same cycle the held word leaves
   assign load_ready = !valid_ff || out_ready;
   assign valid_in   = load ? 1'b1 : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the word on load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### design/stepper_valve_homing_stepper.sv
// Valve stepper drive for up to eight two-phase motors on two shared coil sides.
// Every command or tick word is accepted while req_ready is high; its result
// word is registered and presented on the rsp_ channel in the next cycle, and a
// new word may follow in every cycle while req_ready is high. The only hold-off
// comes from the result register: req_ready drops while a result waits and
// rsp_ready is low. csr_ready is always high. Offsets reset to 150, error flags to 0.
// Depends on svh_pkg, svh_step, svh_rsp_reg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_valve_homing_stepper_macros.svh"

module stepper_valve_homing_stepper #(
   parameter int NUM_MOTORS = svh_pkg::NUM_MOTORS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Command / tick words
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [svh_pkg::MOTOR_W-1:0]       req_motor_id,
   input  logic                              req_direction,
   input  logic [svh_pkg::COUNT_W-1:0]       req_step_count,
   input  logic                              req_homing_mode,
   input  logic                              req_arm_close_check,
   input  logic [svh_pkg::SENSOR_W-1:0]      req_origin_sensors,
   // Result words
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [svh_pkg::PATTERN_W-1:0]     rsp_coil_pattern,
   output logic                              rsp_coil_side,
   output logic [svh_pkg::VALVE_W-1:0]       rsp_valve_enable,
   output logic                              rsp_running,
   output logic [svh_pkg::PERIOD_W-1:0]      rsp_tick_period,
   output logic [svh_pkg::ERRORS_W-1:0]      rsp_close_errors,
   output logic [svh_pkg::OFFSET_W-1:0]      rsp_stored_offset,
   // Register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [svh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [svh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   svh_pkg::svh_cfg_type                           cfg_ff;
   svh_pkg::svh_cfg_type                           cfg_in;
   svh_pkg::svh_state_type                         state_ff;
   svh_pkg::svh_state_type                         state_in;
   logic [NUM_MOTORS-1:0][svh_pkg::OFFSET_W-1:0]   offsets_ff;
   logic [NUM_MOTORS-1:0][svh_pkg::OFFSET_W-1:0]   offsets_in;
   logic [NUM_MOTORS-1:0]                          flags_ff;
   logic [NUM_MOTORS-1:0]                          flags_in;
   svh_pkg::svh_req_type                           req;
   svh_pkg::svh_rsp_type                           step_rsp;
   svh_pkg::svh_rsp_type                           rsp_data;
   logic                                           req_take;

   assign req.req_type        = req_type;
   assign req.motor_id        = req_motor_id;
   assign req.direction       = req_direction;
   assign req.step_count      = req_step_count;
   assign req.homing_mode     = req_homing_mode;
   assign req.arm_close_check = req_arm_close_check;
   assign req.origin_sensors  = req_origin_sensors;

   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            svh_pkg::CSR_GEAR_MODE:   cfg_in.gear_ratio_mode    = csr_wdata[0];
            svh_pkg::CSR_OVERRUN_EN:  cfg_in.overrun_enable     = csr_wdata[0];
            svh_pkg::CSR_OVERRUN_STP: cfg_in.overrun_steps      = csr_wdata;
            svh_pkg::CSR_CLOSE_CHK:   cfg_in.close_check_enable = csr_wdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   svh_step #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_step (
      .req         (req),
      .cfg         (cfg_ff),
      .cur_state   (state_ff),
      .cur_offsets (offsets_ff),
      .cur_flags   (flags_ff),
      .nxt_state   (state_in),
      .nxt_offsets (offsets_in),
      .nxt_flags   (flags_in),
      .rsp         (step_rsp)
   );

   // Hold configuration and run state; advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '0;
         state_ff   <= '0;
         offsets_ff <= {NUM_MOTORS{svh_pkg::ORIGIN_LIMIT}};
         flags_ff   <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_take) begin
            state_ff   <= state_in;
            offsets_ff <= offsets_in;
            flags_ff   <= flags_in;
         end
      end
   end

   svh_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_take),
      .load_data  (step_rsp),
      .load_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_coil_pattern  = rsp_data.coil_pattern;
   assign rsp_coil_side     = rsp_data.coil_side;
   assign rsp_valve_enable  = rsp_data.valve_enable;
   assign rsp_running       = rsp_data.running;
   assign rsp_tick_period   = rsp_data.tick_period;
   assign rsp_close_errors  = rsp_data.close_errors;
   assign rsp_stored_offset = rsp_data.stored_offset;

   // A live run always points at a real motor
   `SVH_ASSERT_IMPLY(a_run_motor, state_ff.run_active, (state_ff.active_motor != '0) && (state_ff.active_motor <= svh_pkg::MOTOR_W'(NUM_MOTORS)))
   // A stopped result drives no coil and no valve
   `SVH_ASSERT_IMPLY(a_idle_quiet, rsp_valid && !rsp_running, (rsp_coil_pattern == '0) && (rsp_valve_enable == '0))
   // A running result powers exactly one valve line
   `SVH_ASSERT_IMPLY(a_valve_onehot, rsp_valid && rsp_running, $onehot(rsp_valve_enable))
   // Close error flags are sticky until reset
   `SVH_ASSERT_IMPLY(a_flags_sticky, !$past(reset), (flags_ff & $past(flags_ff)) == $past(flags_ff))
   // Every accepted word yields a result word next cycle
   `SVH_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid)

endmodule

`default_nettype wire

### tb/sv/stepper_valve_homing_stepper_tb.sv
// Self-checking testbench for the valve stepper drive: a directed opening, then
// random run, origin-search and noise words checked against a local predictor.
// Depends on svh_pkg and the stepper_valve_homing_stepper top level only.
`timescale 1ns / 1ps

module stepper_valve_homing_stepper_tb;

   localparam int NUM_MOTORS = svh_pkg::NUM_MOTORS_DEF;
   localparam logic [7:0] ORIGIN_CAP = 8'd150;
   localparam int STAGE_WORDS = 330;
   localparam int HOLD_CYCLES = 300;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_type;
   logic [svh_pkg::MOTOR_W-1:0]    req_motor_id;
   logic                           req_direction;
   logic [svh_pkg::COUNT_W-1:0]    req_step_count;
   logic                           req_homing_mode;
   logic                           req_arm_close_check;
   logic [svh_pkg::SENSOR_W-1:0]   req_origin_sensors;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [svh_pkg::PATTERN_W-1:0]  rsp_coil_pattern;
   logic                           rsp_coil_side;
   logic [svh_pkg::VALVE_W-1:0]    rsp_valve_enable;
   logic                           rsp_running;
   logic [svh_pkg::PERIOD_W-1:0]   rsp_tick_period;
   logic [svh_pkg::ERRORS_W-1:0]   rsp_close_errors;
   logic [svh_pkg::OFFSET_W-1:0]   rsp_stored_offset;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [svh_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [svh_pkg::CSR_DATA_W-1:0] csr_wdata;

   // One opening row: either a register write or a word with an optional fixed result
   typedef struct {
      bit                             is_reg;
      logic [svh_pkg::CSR_IDX_W-1:0]  idx;
      logic [svh_pkg::CSR_DATA_W-1:0] data;
      svh_pkg::svh_req_type           w;
      bit                             typed;
      svh_pkg::svh_rsp_type           want;
   } drill_row_type;

   // Predicted drive state, registers and per-motor stores
   svh_pkg::svh_state_type st;
   svh_pkg::svh_cfg_type   cfg;
   logic [7:0]             offsets [NUM_MOTORS];
   logic                   err_flags [NUM_MOTORS];

   svh_pkg::svh_rsp_type   drive_words_due [$];
   svh_pkg::svh_rsp_type   due;
   drill_row_type          drill [$];
   int                     failures;
   int                     words_sent;
   int                     send_idle_pct;
   int                     recv_idle_pct;
   int                     hold_ask;
   int                     last_homed;

   stepper_valve_homing_stepper dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("stepper_valve_homing_stepper regression: fail");
      $finish;
   end

   // Latch a new run, scaling and inverting for the 103:1 gear
   function automatic void begin_run(input logic [3:0] motor, input logic dir,
                                     input int unsigned count);
      int unsigned scaled;
      st.active_side   = (motor > 4'd4);
      st.active_motor  = motor;
      st.run_direction = dir;
      st.origin_count  = '0;
      if (cfg.gear_ratio_mode) begin
         scaled = (count * 1757) >> 10;
         st.steps_left = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
         st.run_direction = ~st.run_direction;
      end else begin
         st.steps_left = count[15:0];
      end
      st.run_active = 1'b1;
   endfunction

   // Advance one step on a tick; pat carries the coil levels driven
   function automatic void tick_drive(input logic [7:0] sensors, output logic [3:0] pat);
      int         idx;
      logic       sensor;
      logic       logical_dir;
      logic [1:0] old;
      logic [7:0] c;
      pat = '0;
      if (!st.run_active) return;
      if (st.active_motor < 1 || st.active_motor > NUM_MOTORS) begin
         st.run_active = 1'b0;
         return;
      end
      idx = st.active_motor - 1;
      sensor = sensors[idx];
      logical_dir = st.run_direction ^ cfg.gear_ratio_mode;
      old = st.phase_index;
      case (old)
         2'd0: pat = 4'd6;
         2'd1: pat = 4'd10;
         2'd2: pat = 4'd9;
         default: pat = 4'd5;
      endcase
      st.phase_index = st.run_direction ? old + 2'd3 : old + 2'd1;

      if (!st.run_homing) begin
         // count steps away from the origin; stop at the stored offset
         if (!sensor && !logical_dir) begin
            st.origin_count = st.origin_count + 8'd1;
            if (st.origin_count == offsets[idx]) begin
               st.close_armed = 1'b0;
               st.run_active = 1'b0;
               pat = '0;
               return;
            end
         end else begin
            st.origin_count = '0;
         end
      end else begin
         // origin search: trim the found count by size band and store it, or store the cap
         if (sensor) begin
            c = st.origin_count;
            st.run_active = 1'b0;
            pat = '0;
            if (c > 8'd64) c = c - 8'd48;
            else if (c > 8'd32) c = c - 8'd24;
            else if (c > 8'd16) c = c - 8'd12;
            offsets[idx] = c;
            return;
         end
         st.origin_count = st.origin_count + 8'd1;
         if (st.origin_count >= ORIGIN_CAP) begin
            st.run_active = 1'b0;
            pat = '0;
            offsets[idx] = ORIGIN_CAP;
            return;
         end
      end

      // end of count: latch close error, then maybe one reverse overrun
      st.steps_left = st.steps_left - 16'd1;
      if (st.steps_left == '0) begin
         if (cfg.close_check_enable && st.close_armed) err_flags[idx] = 1'b1;
         pat = '0;
         if (cfg.overrun_enable && !st.reversal_done) begin
            st.reversal_done = 1'b1;
            st.phase_index = st.phase_index ^ 2'd2;
            begin_run(st.active_motor, ~st.run_direction, cfg.overrun_steps + 1);
         end else begin
            st.run_active = 1'b0;
         end
      end
   endfunction

   // Apply one accepted word to the predicted state and return its result word
   function automatic svh_pkg::svh_rsp_type predict_drive_word(
         input svh_pkg::svh_req_type w);
      svh_pkg::svh_rsp_type r;
      logic [3:0]           pat;
      logic [7:0]           errs;
      int                   i;
      pat = '0;
      errs = '0;
      if (w.req_type == svh_pkg::REQ_START) begin
         st.run_active = 1'b0;
         if (w.step_count != '0 && w.motor_id >= 1 && w.motor_id <= NUM_MOTORS) begin
            begin_run(w.motor_id, w.direction, w.step_count);
            st.run_homing = w.homing_mode;
            st.close_armed = w.arm_close_check;
            st.reversal_done = 1'b0;
         end
      end else begin
         tick_drive(w.origin_sensors, pat);
      end
      for (i = 0; i < NUM_MOTORS; i++) errs[i] = err_flags[i];
      r.coil_pattern = st.run_active ? pat : 4'd0;
      r.coil_side = st.active_side;
      if (!st.run_active) r.valve_enable = '0;
      else if (st.active_motor <= 4'd4) r.valve_enable = 4'b0001 << (st.active_motor - 4'd1);
      else r.valve_enable = 4'b0001 << (4'd8 - st.active_motor);
      r.running = st.run_active;
      r.tick_period = cfg.gear_ratio_mode ? 6'd45 : 6'd30;
      r.close_errors = errs;
      r.stored_offset = (st.active_motor >= 1 && st.active_motor <= NUM_MOTORS) ?
                        offsets[st.active_motor - 1] : 8'd0;
      return r;
   endfunction

   function automatic svh_pkg::svh_req_type word_of(input logic t, input logic [3:0] m,
                                                   input logic d, input logic [15:0] c,
                                                   input logic h, input logic a,
                                                   input logic [7:0] s);
      svh_pkg::svh_req_type w;
      w.req_type = t;
      w.motor_id = m;
      w.direction = d;
      w.step_count = c;
      w.homing_mode = h;
      w.arm_close_check = a;
      w.origin_sensors = s;
      return w;
   endfunction

   function automatic svh_pkg::svh_rsp_type result_of(input logic [3:0] pat,
                                                     input logic side,
                                                     input logic [3:0] valve,
                                                     input logic run,
                                                     input logic [5:0] period,
                                                     input logic [7:0] errs,
                                                     input logic [7:0] offs);
      svh_pkg::svh_rsp_type r;
      r.coil_pattern = pat;
      r.coil_side = side;
      r.valve_enable = valve;
      r.running = run;
      r.tick_period = period;
      r.close_errors = errs;
      r.stored_offset = offs;
      return r;
   endfunction

   // Offer one word, hold it until accepted, then queue its expected result
   task automatic send_word(input svh_pkg::svh_req_type w, input bit typed,
                            input svh_pkg::svh_rsp_type want);
      svh_pkg::svh_rsp_type got;
      @(negedge clock);
      // randomly idle the sender before offering the word
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= w.req_type;
      req_motor_id        <= w.motor_id;
      req_direction       <= w.direction;
      req_step_count      <= w.step_count;
      req_homing_mode     <= w.homing_mode;
      req_arm_close_check <= w.arm_close_check;
      req_origin_sensors  <= w.origin_sensors;
      do @(posedge clock); while (req_ready !== 1'b1);
      got = predict_drive_word(w);
      drive_words_due.push_back(typed ? want : got);
      words_sent++;
   endtask

   // Drain all results, wait out the block, then write one register
   task automatic write_reg(input logic [svh_pkg::CSR_IDX_W-1:0] idx,
                            input logic [svh_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_words_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         svh_pkg::CSR_GEAR_MODE:   cfg.gear_ratio_mode = data[0];
         svh_pkg::CSR_OVERRUN_EN:  cfg.overrun_enable = data[0];
         svh_pkg::CSR_OVERRUN_STP: cfg.overrun_steps = data;
         svh_pkg::CSR_CLOSE_CHK:   cfg.close_check_enable = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input logic gear, input logic oen, input logic [7:0] osteps,
                           input logic cchk);
      write_reg(svh_pkg::CSR_GEAR_MODE, {7'd0, gear});
      write_reg(svh_pkg::CSR_OVERRUN_EN, {7'd0, oen});
      write_reg(svh_pkg::CSR_OVERRUN_STP, osteps);
      write_reg(svh_pkg::CSR_CLOSE_CHK, {7'd0, cchk});
   endtask

   // Random mix: origin searches, offset-stop runs and noise words
   task automatic run_stage(input int quota);
      int                   stop_at;
      int                   kind;
      int                   n;
      int                   i;
      int                   m;
      int                   low_pct;
      bit                   long_run;
      logic [7:0]           s;
      svh_pkg::svh_req_type w;
      svh_pkg::svh_rsp_type none;
      none = '0;
      stop_at = words_sent + quota;
      while (words_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         m = $urandom_range(1, NUM_MOTORS);
         w = word_of(svh_pkg::REQ_START, m, $urandom_range(0, 1), 16'd1, 1'b0,
                     $urandom_range(0, 3) != 0, $urandom_range(0, 255));
         if (kind < 30) begin
            // origin search: sensor low for a while, then found
            w.homing_mode = 1'b1;
            w.step_count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60)
                                                       : $urandom_range(200, 65535);
            case ($urandom_range(0, 9))
               0, 1, 2: n = $urandom_range(0, 3);
               3, 4, 5, 6: n = $urandom_range(4, 100);
               7: n = $urandom_range(100, 140);
               default: n = $urandom_range(140, 160);
            endcase
            last_homed = m;
            send_word(w, 1'b0, none);
            i = 0;
            while (st.run_active && i < n) begin
               s = $urandom_range(0, 255);
               s[m-1] = 1'b0;
               send_word(word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, s), 1'b0, none);
               i++;
            end
            if (st.run_active) begin
               s = $urandom_range(0, 255);
               s[m-1] = 1'b1;
               send_word(word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, s), 1'b0, none);
            end
         end else if (kind < 75) begin
            // offset-stop run; a long forward one can wrap the origin count
            long_run = ($urandom_range(0, 9) == 0);
            if (long_run) begin
               if ($urandom_range(0, 1) != 0) m = last_homed;
               w.motor_id = m;
               w.direction = 1'b0;
               w.step_count = $urandom_range(280, 3000);
               n = $urandom_range(270, 320);
               low_pct = 100;
            end else begin
               case ($urandom_range(0, 9))
                  0: w.step_count = $urandom_range(0, 65535);
                  1, 2, 3: w.step_count = $urandom_range(31, 400);
                  default: w.step_count = $urandom_range(1, 30);
               endcase
               n = $urandom_range(5, 60);
               low_pct = 85;
            end
            send_word(w, 1'b0, none);
            i = 0;
            while (st.run_active && i < n) begin
               s = $urandom_range(0, 255);
               if ($urandom_range(0, 99) < low_pct) s[m-1] = 1'b0;
               send_word(word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, s), 1'b0, none);
               i++;
            end
         end else begin
            // noise: any field, any value
            repeat ($urandom_range(1, 6)) begin
               w = word_of($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 1),
                           ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 40),
                           $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 255));
               send_word(w, 1'b0, none);
            end
         end
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_ask != 0) begin
            hold_ask = 0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (drive_words_due.size() == 0) begin
            $error("result word with nothing outstanding");
            failures++;
         end else begin
            due = drive_words_due.pop_front();
            check_field("coil_pattern", due.coil_pattern, rsp_coil_pattern);
            check_field("coil_side", due.coil_side, rsp_coil_side);
            check_field("valve_enable", due.valve_enable, rsp_valve_enable);
            check_field("running", due.running, rsp_running);
            check_field("tick_period", due.tick_period, rsp_tick_period);
            check_field("close_errors", due.close_errors, rsp_close_errors);
            check_field("stored_offset", due.stored_offset, rsp_stored_offset);
         end
      end
   end

   initial begin
      int                   r;
      svh_pkg::svh_rsp_type idle_word;
      svh_pkg::svh_rsp_type none;
      svh_pkg::svh_req_type blank;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = svh_pkg::REQ_TICK;
      req_motor_id = '0;
      req_direction = 1'b0;
      req_step_count = '0;
      req_homing_mode = 1'b0;
      req_arm_close_check = 1'b0;
      req_origin_sensors = '0;
      csr_valid = 1'b0;
      csr_index = svh_pkg::CSR_GEAR_MODE;
      csr_wdata = '0;
      st = '0;
      cfg = '0;
      for (r = 0; r < NUM_MOTORS; r++) begin
         offsets[r] = ORIGIN_CAP;
         err_flags[r] = 1'b0;
      end
      failures = 0;
      words_sent = 0;
      hold_ask = 0;
      last_homed = 1;
      send_idle_pct = 27;
      recv_idle_pct = 76;
      none = '0;
      blank = word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0);
      idle_word = result_of(4'd0, 1'b0, 4'd0, 1'b0, 6'd30, 8'd0, 8'd0);

      // Opening rows: idle tick, rejected starts, runs to the end, overrun,
      // saturated gear count, origin search and an immediate offset stop
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'h00), 1, idle_word});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 0, 0, 5, 0, 0, 8'h00), 1, idle_word});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 15, 1, 16'hFFFF, 1, 1, 8'hFF),
                        1, idle_word});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 9, 0, 5, 0, 0, 8'h00), 1, idle_word});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 1, 0, 0, 0, 1, 8'h00), 1, idle_word});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 1, 0, 2, 0, 1, 8'h00),
                        1, result_of(4'd0, 1'b0, 4'b0001, 1'b1, 6'd30, 8'd0, 8'd150)});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'hFF), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'hFF), 0, none});
      drill.push_back('{1, svh_pkg::CSR_CLOSE_CHK, 8'd1, blank, 0, none});
      drill.push_back('{1, svh_pkg::CSR_OVERRUN_EN, 8'd1, blank, 0, none});
      drill.push_back('{1, svh_pkg::CSR_OVERRUN_STP, 8'd1, blank, 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 2, 1, 1, 0, 1, 8'h00), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'h00), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'hFF), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'hFF), 0, none});
      drill.push_back('{1, svh_pkg::CSR_GEAR_MODE, 8'd1, blank, 0, none});
      drill.push_back('{1, svh_pkg::CSR_OVERRUN_STP, 8'd255, blank, 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 8, 0, 16'hFFFF, 1, 0, 8'h00),
                        1, result_of(4'd0, 1'b1, 4'b0001, 1'b1, 6'd45, 8'h02, 8'd150)});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'h00), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'h80), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 8, 0, 100, 0, 0, 8'h00), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'h00), 0, none});
      drill.push_back('{1, svh_pkg::CSR_GEAR_MODE, 8'd0, blank, 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 5, 0, 40000, 1, 1, 8'h00), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'h10), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_START, 6, 0, 16'hFFFF, 0, 0, 8'h00), 0, none});
      drill.push_back('{0, svh_pkg::CSR_GEAR_MODE, 8'd0,
                        word_of(svh_pkg::REQ_TICK, 0, 0, 0, 0, 0, 8'h00), 0, none});

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (drill[k]) begin
         if (drill[k].is_reg) write_reg(drill[k].idx, drill[k].data);
         else send_word(drill[k].w, drill[k].typed, drill[k].want);
      end

      // Sender idles lightly, receiver heavily
      set_regs(1'b0, 1'b0, 8'd0, 1'b0);
      run_stage(STAGE_WORDS);
      set_regs(1'b1, 1'b1, 8'd255, 1'b1);
      hold_ask = 1;
      run_stage(STAGE_WORDS);

      // Swap the idle rates
      send_idle_pct = 76;
      recv_idle_pct = 27;
      set_regs(1'b0, 1'b1, 8'd0, 1'b1);
      run_stage(STAGE_WORDS);
      set_regs(1'b1, 1'b0, $urandom_range(0, 255), 1'b1);
      run_stage(STAGE_WORDS);

      // No idling; the receiver's long hold-off backs up the input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_regs($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
               $urandom_range(0, 1));
      hold_ask = 1;
      run_stage(STAGE_WORDS);
      set_regs(1'b1, 1'b1, $urandom_range(0, 255), 1'b0);
      run_stage(STAGE_WORDS);

      // Drop valid, drain and let the block settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_words_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (failures == 0) begin
         $display("stepper_valve_homing_stepper regression: pass");
      end else begin
         $display("stepper_valve_homing_stepper regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/svh_pkg.sv
design/svh_step.sv
design/svh_rsp_reg.sv
design/stepper_valve_homing_stepper.sv
tb/sv/stepper_valve_homing_stepper_tb.sv
